// ===== hw/rtl/fss_pkg.sv =====
// ----------------------------------------------------------------------------
// fss_pkg: shared types and constants of the fair-share task scheduler
// Holds the beat structs, slot and request codes, the cell chain control
// structs and the nice-to-weight table.
// ----------------------------------------------------------------------------
package fss_pkg;

  localparam int MAX_TASKS = 32;
  localparam int SLOT_W    = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int ID_W      = 22;
  localparam int VR_W      = 64;
  localparam int ORDER_W   = 32;
  localparam int NICE_IX_W = 6;
  localparam int WEIGHT_W  = 17;
  localparam int SHIFT_W   = 10;
  localparam int DIV_BITS  = VR_W + SHIFT_W;
  localparam int DIV_CNT_W = $clog2(DIV_BITS + 1);
  localparam logic signed [7:0] NICE_MIN  = -8'sd20;
  localparam logic signed [7:0] NICE_MAX  = 8'sd19;
  localparam logic signed [7:0] NICE_BIAS = 8'sd20;

  typedef enum logic [1:0] {
    REQ_CREATE  = 2'd0,
    REQ_BLOCK   = 2'd1,
    REQ_UNBLOCK = 2'd2,
    REQ_SCHED   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_BAD_NICE  = 3'd1,
    STS_FULL      = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_NO_TASK   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_READY   = 2'd1,
    ST_BLOCKED = 2'd2,
    ST_RUNNING = 2'd3
  } slot_st_t;

  typedef enum logic [1:0] {
    SCAN_FREE       = 2'd0,
    SCAN_READY_ID   = 2'd1,
    SCAN_BLOCKED_ID = 2'd2,
    SCAN_READY_ALL  = 2'd3
  } scan_mode_t;

  typedef struct packed {
    req_t                    req_type;
    logic [ID_W-1:0]         task_id;
    logic signed [7:0]       nice_level;
    logic [VR_W-1:0]         now_ns;
  } in_item_t;

  typedef struct packed {
    status_t                 status;
    logic [ID_W-1:0]         picked_id;
    logic [VR_W-1:0]         picked_vruntime;
  } out_item_t;

  // Best entry so far, handed from cell to cell during a scan.
  typedef struct packed {
    logic                    valid;
    logic [SLOT_W-1:0]       slot;
    logic [VR_W-1:0]         vr;
    logic [ORDER_W-1:0]      age;
    logic [ID_W-1:0]         id;
    logic [NICE_IX_W-1:0]    nice;
  } cand_t;

  typedef struct packed {
    scan_mode_t              mode;
    logic [ID_W-1:0]         id;
    logic [ORDER_W-1:0]      counter;
  } scan_ctl_t;

  typedef struct packed {
    logic                    en;
    logic [SLOT_W-1:0]       slot;
    slot_st_t                state;
    logic                    load_info;
    logic [ID_W-1:0]         id;
    logic [NICE_IX_W-1:0]    nice;
    logic                    load_vr;
    logic [VR_W-1:0]         vr;
    logic                    stamp;
    logic [ORDER_W-1:0]      order;
  } wr_t;

  function automatic logic [WEIGHT_W-1:0] nice_weight(input logic [NICE_IX_W-1:0] ix);
    logic [WEIGHT_W-1:0] w;
    unique case (ix)
      6'd0:  w = 17'd88761;  6'd1:  w = 17'd71755;  6'd2:  w = 17'd56483;
      6'd3:  w = 17'd46273;  6'd4:  w = 17'd36291;  6'd5:  w = 17'd29154;
      6'd6:  w = 17'd23254;  6'd7:  w = 17'd18705;  6'd8:  w = 17'd14949;
      6'd9:  w = 17'd11916;  6'd10: w = 17'd9548;   6'd11: w = 17'd7620;
      6'd12: w = 17'd6100;   6'd13: w = 17'd4904;   6'd14: w = 17'd3906;
      6'd15: w = 17'd3121;   6'd16: w = 17'd2501;   6'd17: w = 17'd1991;
      6'd18: w = 17'd1586;   6'd19: w = 17'd1277;   6'd20: w = 17'd1024;
      6'd21: w = 17'd820;    6'd22: w = 17'd655;    6'd23: w = 17'd526;
      6'd24: w = 17'd423;    6'd25: w = 17'd335;    6'd26: w = 17'd272;
      6'd27: w = 17'd215;    6'd28: w = 17'd172;    6'd29: w = 17'd137;
      6'd30: w = 17'd110;    6'd31: w = 17'd87;     6'd32: w = 17'd70;
      6'd33: w = 17'd56;     6'd34: w = 17'd45;     6'd35: w = 17'd36;
      6'd36: w = 17'd29;     6'd37: w = 17'd23;     6'd38: w = 17'd18;
      6'd39: w = 17'd15;
      default: w = 17'd1024;
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/fair_share_task_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// fair_share_task_scheduler_core: fair-share task scheduler
// Task table kept in a chain of slot cells; searches pass a candidate along
// the chain, the runtime charge uses a bit-serial divider.
//
//   channel  ports                  handshake
//   input    start, busy, in_item   beat taken when start && !busy
//   result   out_valid, out_item    one-cycle strobe, one beat per request
//
// Create, block and unblock run a scan through the cell chain. Schedule runs
// the same scan, and first charges the running task, if any, through the
// divider (one bit a cycle). A create with a bad nice answers in the cycle
// after it is taken, without a scan. Reset empties the table at once. The
// receiver cannot stall; busy stays high until the result beat.
// ----------------------------------------------------------------------------
module fair_share_task_scheduler_core import fss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_CHARGE, S_SCAN} fsm_t;

  fsm_t                 state_r;
  in_item_t             req_r;
  scan_ctl_t            ctl_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [ORDER_W-1:0]   order_cnt_r;
  logic                 run_valid_r;
  logic [SLOT_W-1:0]    run_slot_r;
  logic [NICE_IX_W-1:0] run_nice_r;
  logic [VR_W-1:0]      run_vr_r;
  logic [VR_W-1:0]      run_start_r;
  logic [VR_W-1:0]      floor_r;
  logic                 out_valid_r;
  out_item_t            out_item_r;
  out_item_t            out_item_nxt;

  logic                 accept;
  logic                 scan_done;
  logic                 div_start;
  logic                 div_done;
  logic [VR_W-1:0]      div_quo;
  logic                 bad_nice;
  logic [7:0]           nice_sum;
  cand_t                best;
  wr_t                  wr;
  cand_t                chain [0:MAX_TASKS];

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign bad_nice  = (in_item.nice_level < NICE_MIN) || (in_item.nice_level > NICE_MAX);
  assign nice_sum  = 8'(req_r.nice_level + NICE_BIAS);
  assign scan_done = (state_r == S_SCAN) && (cnt_r == CNT_W'(MAX_TASKS));
  assign best      = chain[MAX_TASKS];
  assign div_start = accept && (in_item.req_type == REQ_SCHED) && run_valid_r;

  assign chain[0] = '0;

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    fss_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (SLOT_W'(g)),
      .ctl      (ctl_r),
      .wr       (wr),
      .cand_i   (chain[g]),
      .cand_o   (chain[g+1])
    );
  end

  fss_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .delta  (in_item.now_ns - run_start_r),
    .weight (nice_weight(run_nice_r)),
    .done   (div_done),
    .quo    (div_quo)
  );

  // Slot write: the charge of the running task, or the result of a scan.
  always_comb begin
    wr           = '0;
    wr.order     = order_cnt_r;
    wr.id        = req_r.task_id;
    wr.nice      = nice_sum[NICE_IX_W-1:0];
    wr.vr        = floor_r;
    wr.slot      = best.slot;
    if (state_r == S_CHARGE) begin
      wr.en    = 1'b1;
      wr.slot  = run_slot_r;
      wr.state = ST_READY;
      wr.load_vr = 1'b1;
      wr.vr    = run_vr_r + div_quo;
      wr.stamp = 1'b1;
    end else if (scan_done && best.valid) begin
      wr.en = 1'b1;
      unique case (req_r.req_type)
        REQ_CREATE: begin
          wr.state     = ST_READY;
          wr.load_info = 1'b1;
          wr.load_vr   = 1'b1;
          wr.stamp     = 1'b1;
        end
        REQ_BLOCK: begin
          wr.state = ST_BLOCKED;
          wr.stamp = 1'b1;
        end
        REQ_UNBLOCK: begin
          wr.state   = ST_READY;
          wr.load_vr = 1'b1;
          wr.stamp   = 1'b1;
        end
        REQ_SCHED: begin
          wr.state = ST_RUNNING;
        end
        default: wr.state = ST_FREE;
      endcase
    end
  end

  // Result beat at the end of a scan.
  always_comb begin
    out_item_nxt = '{status: STS_OK, picked_id: '0, picked_vruntime: '0};
    if (!best.valid) begin
      unique case (req_r.req_type)
        REQ_CREATE: out_item_nxt.status = STS_FULL;
        REQ_SCHED:  out_item_nxt.status = STS_NO_TASK;
        default:    out_item_nxt.status = STS_NOT_FOUND;
      endcase
    end else if (req_r.req_type == REQ_SCHED) begin
      out_item_nxt.picked_id       = best.id;
      out_item_nxt.picked_vruntime = best.vr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      order_cnt_r <= '0;
      run_valid_r <= 1'b0;
      run_slot_r  <= '0;
      run_start_r <= '0;
      floor_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (wr.en && wr.stamp) begin
        order_cnt_r <= order_cnt_r + 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cnt_r <= '0;
            priority if (in_item.req_type == REQ_CREATE && bad_nice) begin
              out_valid_r <= 1'b1;
              out_item_r  <= '{status: STS_BAD_NICE, picked_id: '0, picked_vruntime: '0};
            end else if (div_start) begin
              state_r <= S_DIV;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_CHARGE;
          end
        end
        S_CHARGE: begin
          run_valid_r <= 1'b0;
          state_r     <= S_SCAN;
        end
        S_SCAN: begin
          cnt_r <= cnt_r + 1'b1;
          if (scan_done) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            out_item_r  <= out_item_nxt;
            if (best.valid && req_r.req_type == REQ_SCHED) begin
              if (best.vr > floor_r) begin
                floor_r <= best.vr;
              end
              run_valid_r <= 1'b1;
              run_slot_r  <= best.slot;
              run_nice_r  <= best.nice;
              run_vr_r    <= best.vr;
              run_start_r <= req_r.now_ns;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_item;
      ctl_r.id      <= in_item.task_id;
      ctl_r.counter <= order_cnt_r;
      unique case (in_item.req_type)
        REQ_CREATE:  ctl_r.mode <= SCAN_FREE;
        REQ_BLOCK:   ctl_r.mode <= SCAN_READY_ID;
        REQ_UNBLOCK: ctl_r.mode <= SCAN_BLOCKED_ID;
        default:     ctl_r.mode <= SCAN_READY_ALL;
      endcase
    end else if (state_r == S_CHARGE) begin
      // The charge stamps the running task, so the scan sees the new count.
      ctl_r.counter <= order_cnt_r + 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result beat while still busy");

  a_run_below_floor: assert property (@(posedge clk) disable iff (!rst_n)
    run_valid_r |-> (run_vr_r <= floor_r))
    else $error("running task above the floor");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !(in_item.req_type == REQ_CREATE && bad_nice)) |=> busy)
    else $error("request accepted without going busy");

  a_no_task_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.status == STS_NO_TASK) |-> !run_valid_r)
    else $error("task left running with nothing to run");

endmodule

// ===== hw/rtl/fss_cell.sv =====
// ----------------------------------------------------------------------------
// fss_cell: one task slot of the scheduler chain
// Holds one slot and, during a scan, passes on the better of its own entry
// and the candidate from its left neighbor.
// ----------------------------------------------------------------------------
module fss_cell import fss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SLOT_W-1:0] cell_idx,
  input  scan_ctl_t         ctl,
  input  wr_t               wr,
  input  cand_t             cand_i,
  output cand_t             cand_o
);

  slot_st_t             state_r;
  logic [ID_W-1:0]      id_r;
  logic [NICE_IX_W-1:0] nice_r;
  logic [VR_W-1:0]      vr_r;
  logic [ORDER_W-1:0]   order_r;
  cand_t                cand_r;
  cand_t                mine;
  logic [ORDER_W-1:0]   age;
  logic                 wr_hit;
  logic                 earlier;
  logic                 elig;
  logic                 take;

  assign wr_hit  = wr.en && (wr.slot == cell_idx);
  assign age     = ctl.counter - order_r;
  assign earlier = (vr_r < cand_i.vr) || ((vr_r == cand_i.vr) && (age > cand_i.age));

  always_comb begin
    mine.valid = 1'b1;
    mine.slot  = cell_idx;
    mine.vr    = vr_r;
    mine.age   = age;
    mine.id    = id_r;
    mine.nice  = nice_r;
    unique case (ctl.mode)
      SCAN_FREE: begin
        elig = (state_r == ST_FREE);
        take = elig && !cand_i.valid;
      end
      SCAN_READY_ID: begin
        elig = (state_r == ST_READY) && (id_r == ctl.id);
        take = elig && (!cand_i.valid || earlier);
      end
      SCAN_BLOCKED_ID: begin
        elig = (state_r == ST_BLOCKED) && (id_r == ctl.id);
        take = elig && (!cand_i.valid || (age > cand_i.age));
      end
      SCAN_READY_ALL: begin
        elig = (state_r == ST_READY);
        take = elig && (!cand_i.valid || earlier);
      end
      default: begin
        elig = 1'b0;
        take = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FREE;
    end else if (wr_hit) begin
      state_r <= wr.state;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit && wr.load_info) begin
      id_r   <= wr.id;
      nice_r <= wr.nice;
    end
    if (wr_hit && wr.load_vr) begin
      vr_r <= wr.vr;
    end
    if (wr_hit && wr.stamp) begin
      order_r <= wr.order;
    end
    cand_r <= take ? mine : cand_i;
  end

  assign cand_o = cand_r;

endmodule

// ===== hw/rtl/fss_div.sv =====
// ----------------------------------------------------------------------------
// fss_div: bit-serial divider for the runtime charge
// Computes (delta * 1024) / weight, keeping the low 64 quotient bits, one
// quotient bit per cycle by restoring division.
// ----------------------------------------------------------------------------
module fss_div import fss_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [VR_W-1:0]     delta,
  input  logic [WEIGHT_W-1:0] weight,
  output logic                done,
  output logic [VR_W-1:0]     quo
);

  logic                   run_r;
  logic                   done_r;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic [DIV_BITS-1:0]    dvd_r;
  logic [WEIGHT_W-1:0]    w_r;
  logic [WEIGHT_W-1:0]    rem_r;
  logic [VR_W-1:0]        quo_r;
  logic [WEIGHT_W:0]      rem_sh;
  logic                   ge;
  logic [WEIGHT_W-1:0]    rem_nxt;

  assign rem_sh  = {rem_r, dvd_r[DIV_BITS-1]};
  assign ge      = rem_sh >= {1'b0, w_r};
  assign rem_nxt = ge ? WEIGHT_W'(rem_sh - {1'b0, w_r}) : rem_sh[WEIGHT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_BITS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {delta, SHIFT_W'(0)};
      w_r   <= weight;
      rem_r <= '0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[DIV_BITS-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[VR_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
